### hw/rtl/dalt_pkg.sv
// shared types, constants and helper functions for the dual-axis light tracker
// no dependencies; used by dalt_step and dual_axis_light_tracker_stepper
`default_nettype none

package dalt_pkg;

    // register reset values
    localparam logic [7:0] EngageTolRst  = 8'd15;
    localparam logic [7:0] VertRelRst    = 8'd4;
    localparam logic [7:0] HorzRelRst    = 8'd7;
    localparam logic [7:0] BlinkLimitRst = 8'd39;

    localparam logic [7:0] ReadingMin = 8'h00;
    localparam logic [7:0] ReadingMax = 8'hff;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_ENGAGE_TOL  = 2'd0,
        CFG_VERT_REL    = 2'd1,
        CFG_HORZ_REL    = 2'd2,
        CFG_BLINK_LIMIT = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] engage_tolerance;
        logic [7:0] vertical_release;
        logic [7:0] horizontal_release;
        logic [7:0] blink_limit;
    } t_cfg;

    typedef struct packed {
        t_opcode    opcode;
        logic [7:0] light_up;
        logic [7:0] light_down;
        logic [7:0] light_left;
        logic [7:0] light_right;
        logic       press_up;
        logic       press_down;
        logic       press_left;
        logic       press_right;
        logic       mode_toggle;
    } t_item;

    typedef struct packed {
        logic       move_up;
        logic       move_down;
        logic       move_left;
        logic       move_right;
        logic       mode_auto;
        logic       fault_flag;
        logic [2:0] phase_index;
        logic [7:0] blink_count;
        logic       lamp_a_level;
        logic       lamp_b_level;
        logic [7:0] drive_port;
    } t_state;

    // half-step coil patterns, forward direction
    function automatic logic [3:0] phase_fwd(input logic [2:0] p);
        logic [3:0] v;
        case (p)
            3'd0:    v = 4'h1;
            3'd1:    v = 4'h3;
            3'd2:    v = 4'h2;
            3'd3:    v = 4'h6;
            3'd4:    v = 4'h4;
            3'd5:    v = 4'hc;
            3'd6:    v = 4'h8;
            3'd7:    v = 4'h9;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

    // half-step coil patterns, reverse direction
    function automatic logic [3:0] phase_rev(input logic [2:0] p);
        logic [3:0] v;
        case (p)
            3'd0:    v = 4'h9;
            3'd1:    v = 4'h8;
            3'd2:    v = 4'hc;
            3'd3:    v = 4'h4;
            3'd4:    v = 4'h6;
            3'd5:    v = 4'h2;
            3'd6:    v = 4'h3;
            3'd7:    v = 4'h1;
            default: v = 4'h0;
        endcase
        return v;
    endfunction

    // engage wins over release
    function automatic logic hyst(input logic flag, input logic [7:0] diff,
                                  input logic [7:0] engage, input logic [7:0] release_lvl);
        logic v;
        if (diff >= engage) begin
            v = 1'b1;
        end else if (diff <= release_lvl) begin
            v = 1'b0;
        end else begin
            v = flag;
        end
        return v;
    endfunction

    function automatic logic bad_reading(input logic [7:0] r);
        return (r == ReadingMin) || (r == ReadingMax);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/dalt_step.sv
// next-state logic for one sample or tick transaction
// depends on dalt_pkg
`default_nettype none

module dalt_step (
    input  var dalt_pkg::t_cfg   i_cfg,
    input  var dalt_pkg::t_item  i_item,
    input  var dalt_pkg::t_state i_state,
    output dalt_pkg::t_state     o_state
);

    logic       ma;
    logic       fault;
    logic       mu, md, ml, mr;
    logic [7:0] v_diff, h_diff;
    logic [3:0] lo, hi;
    logic [7:0] bc_inc;

    always_comb begin
        o_state = i_state;

        // sample path
        ma    = i_state.mode_auto ^ i_item.mode_toggle;
        mu    = i_item.mode_toggle ? 1'b0 : i_state.move_up;
        md    = i_item.mode_toggle ? 1'b0 : i_state.move_down;
        ml    = i_item.mode_toggle ? 1'b0 : i_state.move_left;
        mr    = i_item.mode_toggle ? 1'b0 : i_state.move_right;
        fault = dalt_pkg::bad_reading(i_item.light_up)
              | dalt_pkg::bad_reading(i_item.light_down)
              | dalt_pkg::bad_reading(i_item.light_left)
              | dalt_pkg::bad_reading(i_item.light_right);
        v_diff = (i_item.light_up > i_item.light_down)
               ? i_item.light_up - i_item.light_down
               : i_item.light_down - i_item.light_up;
        h_diff = (i_item.light_left > i_item.light_right)
               ? i_item.light_left - i_item.light_right
               : i_item.light_right - i_item.light_left;

        // tick path
        lo = i_state.move_up   ? dalt_pkg::phase_fwd(i_state.phase_index) :
             i_state.move_down ? dalt_pkg::phase_rev(i_state.phase_index) : 4'h0;
        hi = i_state.move_left  ? dalt_pkg::phase_fwd(i_state.phase_index) :
             i_state.move_right ? dalt_pkg::phase_rev(i_state.phase_index) : 4'h0;
        bc_inc = i_state.blink_count + 8'd1;

        case (i_item.opcode)
            dalt_pkg::OP_SAMPLE: begin
                if (!ma) begin
                    mu = i_item.press_up;
                    md = !i_item.press_up && i_item.press_down;
                    ml = i_item.press_left;
                    mr = !i_item.press_left && i_item.press_right;
                end else if (fault) begin
                    mu = 1'b0;
                    md = 1'b0;
                    ml = 1'b0;
                    mr = 1'b0;
                end else begin
                    if (i_item.light_up > i_item.light_down) begin
                        mu = 1'b0;
                        md = dalt_pkg::hyst(md, v_diff, i_cfg.engage_tolerance,
                                            i_cfg.vertical_release);
                    end else begin
                        md = 1'b0;
                        mu = dalt_pkg::hyst(mu, v_diff, i_cfg.engage_tolerance,
                                            i_cfg.vertical_release);
                    end
                    if (i_item.light_left > i_item.light_right) begin
                        mr = 1'b0;
                        ml = dalt_pkg::hyst(ml, h_diff, i_cfg.engage_tolerance,
                                            i_cfg.horizontal_release);
                    end else begin
                        ml = 1'b0;
                        mr = dalt_pkg::hyst(mr, h_diff, i_cfg.engage_tolerance,
                                            i_cfg.horizontal_release);
                    end
                end
                o_state.move_up    = mu;
                o_state.move_down  = md;
                o_state.move_left  = ml;
                o_state.move_right = mr;
                o_state.mode_auto  = ma;
                o_state.fault_flag = fault;
                if (!fault) begin
                    o_state.lamp_a_level = ma;
                    o_state.lamp_b_level = !ma;
                end
            end
            dalt_pkg::OP_TICK: begin
                o_state.drive_port  = {hi, lo};
                o_state.phase_index = i_state.phase_index + 3'd1;
                if (i_state.fault_flag) begin
                    if (bc_inc > i_cfg.blink_limit) begin
                        o_state.blink_count  = 8'd0;
                        o_state.lamp_a_level = !i_state.lamp_a_level;
                        o_state.lamp_b_level = !i_state.lamp_a_level;
                    end else begin
                        o_state.blink_count = bc_inc;
                    end
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/dual_axis_light_tracker_stepper.sv
// dual-axis light tracker with half-step stepper drive: top level
// depends on dalt_pkg and dalt_step
// datapath: each transaction passes through the input register, then the result register
// throughput: one transaction per cycle, both sides may stall independently
// reset (synchronous, active low): config registers to defaults, tracker state to idle values
// configuration port always ready, one register written per transaction
`default_nettype none

module dual_axis_light_tracker_stepper (
    input  wire        i_clk,
    input  wire        i_rst_n,
    // item channel
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire        i_opcode,
    input  wire  [7:0] i_light_up,
    input  wire  [7:0] i_light_down,
    input  wire  [7:0] i_light_left,
    input  wire  [7:0] i_light_right,
    input  wire        i_press_up,
    input  wire        i_press_down,
    input  wire        i_press_left,
    input  wire        i_press_right,
    input  wire        i_mode_toggle,
    // result channel
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [7:0] o_motor_drive,
    output logic       o_lamp_a,
    output logic       o_lamp_b,
    output logic       o_auto_active,
    output logic       o_sensor_fault,
    // configuration channel
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire  [1:0] i_cfg_index,
    input  wire  [7:0] i_cfg_data
);

    // configuration registers
    dalt_pkg::t_cfg   r_cfg;

    // input stage
    logic             r_in_valid;
    dalt_pkg::t_item  r_item;
    dalt_pkg::t_item  n_item;

    // tracker state, updated when the input stage hands over to the result stage
    dalt_pkg::t_state r_state;
    dalt_pkg::t_state n_state;

    // result stage
    logic             r_out_valid;
    logic [7:0]       r_motor_drive;
    logic             r_lamp_a;
    logic             r_lamp_b;
    logic             r_auto_active;
    logic             r_sensor_fault;

    logic             out_free;
    logic             advance;
    logic             in_take;

    // result register can take a new transaction when empty or being drained
    assign out_free   = !r_out_valid || i_out_ready;
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;
    assign in_take    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign n_item = '{
        opcode:      dalt_pkg::t_opcode'(i_opcode),
        light_up:    i_light_up,
        light_down:  i_light_down,
        light_left:  i_light_left,
        light_right: i_light_right,
        press_up:    i_press_up,
        press_down:  i_press_down,
        press_left:  i_press_left,
        press_right: i_press_right,
        mode_toggle: i_mode_toggle
    };

    // one pass of sample or tick handling
    dalt_step u_step (
        .i_cfg   (r_cfg),
        .i_item  (r_item),
        .i_state (r_state),
        .o_state (n_state)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.engage_tolerance   <= dalt_pkg::EngageTolRst;
            r_cfg.vertical_release   <= dalt_pkg::VertRelRst;
            r_cfg.horizontal_release <= dalt_pkg::HorzRelRst;
            r_cfg.blink_limit        <= dalt_pkg::BlinkLimitRst;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (dalt_pkg::t_cfg_index'(i_cfg_index))
                dalt_pkg::CFG_ENGAGE_TOL:  r_cfg.engage_tolerance   <= i_cfg_data;
                dalt_pkg::CFG_VERT_REL:    r_cfg.vertical_release   <= i_cfg_data;
                dalt_pkg::CFG_HORZ_REL:    r_cfg.horizontal_release <= i_cfg_data;
                dalt_pkg::CFG_BLINK_LIMIT: r_cfg.blink_limit        <= i_cfg_data;
                default:                   r_cfg <= r_cfg;
            endcase
        end
    end

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= n_item;
        end
    end

    // tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.move_up      <= 1'b0;
            r_state.move_down    <= 1'b0;
            r_state.move_left    <= 1'b0;
            r_state.move_right   <= 1'b0;
            r_state.mode_auto    <= 1'b0;
            r_state.fault_flag   <= 1'b0;
            r_state.phase_index  <= 3'd0;
            r_state.blink_count  <= 8'd0;
            r_state.lamp_a_level <= 1'b1;
            r_state.lamp_b_level <= 1'b1;
            r_state.drive_port   <= 8'd0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result payload taken from the updated state
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_motor_drive  <= n_state.drive_port;
            r_lamp_a       <= n_state.lamp_a_level;
            r_lamp_b       <= n_state.lamp_b_level;
            r_auto_active  <= n_state.mode_auto;
            r_sensor_fault <= n_state.fault_flag;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_motor_drive  = r_motor_drive;
    assign o_lamp_a       = r_lamp_a;
    assign o_lamp_b       = r_lamp_b;
    assign o_auto_active  = r_auto_active;
    assign o_sensor_fault = r_sensor_fault;

    // never drive both directions of an axis
    a_axis_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.move_up && r_state.move_down) && !(r_state.move_left && r_state.move_right))
        else $error("both directions of an axis set");

    // a faulty reading in automatic mode stops both motors
    a_fault_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.mode_auto && r_state.fault_flag) |->
        !(r_state.move_up || r_state.move_down || r_state.move_left || r_state.move_right))
        else $error("motor flag set during automatic-mode fault");

    // each tick moves the phase on by one
    a_tick_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_item.opcode == dalt_pkg::OP_TICK)) |=>
        (r_state.phase_index == 3'($past(r_state.phase_index) + 3'd1)))
        else $error("phase did not advance on tick");

endmodule

`default_nettype wire
